// ===== hdl/oof_pkg.sv =====
// shared constants for the occupancy odds fusion block
// no dependencies
package oof_pkg;

  localparam int MAX_MAPS = 8;
  localparam int ODDS_W   = 54;
  localparam int CNT_W    = 4;
  localparam int PCT_W    = 8;
  localparam int MULB_W   = 8;
  localparam int SUM_W    = ODDS_W + 1;
  localparam int QUOT_W   = 7;
  localparam int REM_W    = ODDS_W + 9;
  localparam int DSR_W    = SUM_W + QUOT_W;
  localparam int STEP_W   = 3;

  localparam logic [PCT_W-1:0]  PCT_UNKNOWN = 8'hFF;
  localparam logic [PCT_W-1:0]  PCT_FULL    = 8'd100;
  localparam logic [PCT_W-1:0]  PCT_MAX_USE = 8'd99;
  localparam logic [MULB_W-1:0] ROUND_SCALE = 8'd200;
  localparam logic [ODDS_W-1:0] ODDS_ONE    = {{(ODDS_W-1){1'b0}}, 1'b1};

endpackage

// ===== hdl/occupancy_odds_fusion.sv =====
// occupancy odds fusion top level: product of odds and rounding divider
// depends on oof_pkg
//
// Takes one occupancy value per map for a grid cell, the last one marked, and
// returns round(100*num/(num+den)) or -1 when the odds product is one. A value
// that is skipped (unknown, 100, out of range or beyond MAX_MAPS) leaves the
// odds alone. A usable value passes ST_MUL_NUM and ST_MUL_DEN: the numerator
// and denominator updates run one after the other through a single shared
// 54x8 multiplier. The marked value then passes setup in ST_PREP (the same
// multiplier forms 200*num) and ST_ADD, restoring division in ST_DIV with one
// shared 63-bit compare and subtract, one bit per cycle, and ST_DONE to load
// the output register; when num equals den the division is bypassed. in_ready
// is high only while no value is being worked on. The result waits in an
// output register, so a new cell may start while the previous result is held.
module occupancy_odds_fusion (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [oof_pkg::PCT_W-1:0] in_cell_value,
  input  logic                           in_last_map,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [oof_pkg::PCT_W-1:0] out_fused_value,
  output logic                           out_too_many
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_PREP,
    ST_ADD,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                          state_r;
  logic [oof_pkg::ODDS_W-1:0]      num_r;
  logic [oof_pkg::ODDS_W-1:0]      den_r;
  logic [oof_pkg::CNT_W-1:0]       cnt_r;
  logic                            ovf_r;
  logic [oof_pkg::PCT_W-2:0]       c_r;
  logic                            last_r;
  logic                            eq_r;
  logic [oof_pkg::SUM_W-1:0]       sum_r;
  logic [oof_pkg::REM_W-1:0]       rem_r;
  logic [oof_pkg::DSR_W-1:0]       dsr_r;
  logic [oof_pkg::QUOT_W-1:0]      quot_r;
  logic [oof_pkg::STEP_W-1:0]      step_r;
  logic                            out_valid_r;
  logic [oof_pkg::PCT_W-1:0]       out_fused_r;
  logic                            out_too_many_r;

  logic                            in_acc;
  logic                            usable;
  logic                            room;
  logic [oof_pkg::ODDS_W-1:0]      mul_a;
  logic [oof_pkg::MULB_W-1:0]      mul_b;
  logic [oof_pkg::ODDS_W+oof_pkg::MULB_W-1:0] mul_p;
  logic [oof_pkg::REM_W:0]         sub_d;
  logic                            sub_ok;
  logic                            load_out;
  logic [oof_pkg::PCT_W-1:0]       fused;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign usable   = !in_cell_value[oof_pkg::PCT_W-1] &&
                    ($unsigned(in_cell_value) <= oof_pkg::PCT_MAX_USE);
  assign room     = (cnt_r < oof_pkg::CNT_W'(oof_pkg::MAX_MAPS));

  // shared multiplier: numerator, denominator, then 200*num for rounding
  always_comb begin
    mul_a = num_r;
    mul_b = {1'b0, c_r};
    case (state_r)
      ST_MUL_NUM: begin
        mul_a = num_r;
        mul_b = {1'b0, c_r};
      end
      ST_MUL_DEN: begin
        mul_a = den_r;
        mul_b = oof_pkg::PCT_FULL - {1'b0, c_r};
      end
      ST_PREP: begin
        mul_a = num_r;
        mul_b = oof_pkg::ROUND_SCALE;
      end
      default: begin
        mul_a = num_r;
        mul_b = {1'b0, c_r};
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // shared compare and subtract of the restoring divider
  assign sub_d  = {1'b0, rem_r} - {{(oof_pkg::REM_W+1-oof_pkg::DSR_W){1'b0}}, dsr_r};
  assign sub_ok = !sub_d[oof_pkg::REM_W];

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  always_comb begin
    if (eq_r) begin
      fused = oof_pkg::PCT_UNKNOWN;
    end else if ({1'b0, quot_r} > oof_pkg::PCT_FULL) begin
      fused = oof_pkg::PCT_FULL;
    end else begin
      fused = {1'b0, quot_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      num_r       <= oof_pkg::ODDS_ONE;
      den_r       <= oof_pkg::ODDS_ONE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            c_r    <= in_cell_value[oof_pkg::PCT_W-2:0];
            last_r <= in_last_map;
            if (usable && room) begin
              cnt_r   <= cnt_r + 1'b1;
              state_r <= ST_MUL_NUM;
            end else begin
              if (usable) begin
                ovf_r <= 1'b1;
              end
              if (in_last_map) begin
                state_r <= ST_PREP;
              end
            end
          end
        end
        ST_MUL_NUM: begin
          num_r   <= mul_p[oof_pkg::ODDS_W-1:0];
          state_r <= ST_MUL_DEN;
        end
        ST_MUL_DEN: begin
          den_r   <= mul_p[oof_pkg::ODDS_W-1:0];
          state_r <= last_r ? ST_PREP : ST_IDLE;
        end
        ST_PREP: begin
          eq_r   <= (num_r == den_r);
          rem_r  <= oof_pkg::REM_W'(mul_p);
          sum_r  <= {1'b0, num_r} + {1'b0, den_r};
          quot_r <= '0;
          state_r <= (num_r == den_r) ? ST_DONE : ST_ADD;
        end
        ST_ADD: begin
          // dividend 200*num + sum, divisor 2*sum aligned to the top quotient bit
          rem_r   <= rem_r + oof_pkg::REM_W'(sum_r);
          dsr_r   <= {sum_r, {oof_pkg::QUOT_W{1'b0}}};
          step_r  <= oof_pkg::STEP_W'(oof_pkg::QUOT_W - 1);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (sub_ok) begin
            rem_r <= sub_d[oof_pkg::REM_W-1:0];
          end
          quot_r <= {quot_r[oof_pkg::QUOT_W-2:0], sub_ok};
          dsr_r  <= dsr_r >> 1;
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            out_fused_r    <= fused;
            out_too_many_r <= ovf_r;
            num_r          <= oof_pkg::ODDS_ONE;
            den_r          <= oof_pkg::ODDS_ONE;
            cnt_r          <= '0;
            ovf_r          <= 1'b0;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fused_value = $signed(out_fused_r);
  assign out_too_many    = out_too_many_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= oof_pkg::CNT_W'(oof_pkg::MAX_MAPS))
    else $error("usable count above limit");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && step_r == '0) |=> (quot_r <= oof_pkg::QUOT_W'(100)))
    else $error("quotient beyond 100");

  a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (num_r == oof_pkg::ODDS_ONE && den_r == oof_pkg::ODDS_ONE &&
                  cnt_r == '0 && !ovf_r))
    else $error("cell state not cleared after result");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fused_r == oof_pkg::PCT_UNKNOWN ||
                     out_fused_r <= oof_pkg::PCT_FULL))
    else $error("fused value out of range");

  a_unknown_only_on_tie: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && fused == oof_pkg::PCT_UNKNOWN) |-> (num_r == den_r))
    else $error("unknown result without equal odds");

endmodule
